FILE: rtl/scc_pkg.sv
// ----------------------------------------------------------------------------
// scc_pkg
// Shared types and constants for the stack sequence checker.
// ----------------------------------------------------------------------------
`default_nettype none

package scc_pkg;

   localparam int DEF_MAX_LEN = 256;
   localparam int TARGET_W    = 9;
   localparam int COUNT_W     = 9;
   localparam int LEN_W       = 9;

   localparam logic [LEN_W-1:0] LEN_RESET = 9'd256;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EVAL,
      ST_PUSH
   } state_type;

   typedef struct packed {
      logic              last;
      logic              failed;
      logic [COUNT_W-1:0] push_count;
   } rsp_type;

endpackage

`default_nettype wire

FILE: rtl/stack_sequence_checker_unit.sv
// ----------------------------------------------------------------------------
// stack_sequence_checker_unit
// Checks a stream of pop targets against a stack fed with 1..n in order.
// ----------------------------------------------------------------------------
// Each req transaction carries one target; each rsp transaction returns the
// pushes done before that target's pop, the sticky fail flag, and tlast on the
// nth target, after which the checker starts a new sequence. A target that
// matches the stack top or is unreachable is answered from the EVAL state; a
// target that needs pushes moves on to the PUSH state, one value pushed per
// cycle through the single write port of the stack memory. A finished result
// waits in an output register while the next target is accepted. n comes from
// the csr register (reset 256, 0 acts as 1, clipped to MAX_LEN). No clearing
// pass is needed after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module stack_sequence_checker_unit #(
   parameter int MAX_LEN = scc_pkg::DEF_MAX_LEN
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      csr_valid,
   output logic                           csr_ready,
   input  wire logic [scc_pkg::LEN_W-1:0] csr_data,   // seq_length
   input  wire logic                      req_tvalid,
   output logic                           req_tready,
   input  wire logic [15:0]               req_tdata,  // [8:0] target
   output logic                           rsp_tvalid,
   input  wire logic                      rsp_tready,
   output logic      [15:0]               rsp_tdata,  // [8:0] push_count, [9] failed
   output logic                           rsp_tlast
);

   import scc_pkg::*;

   localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
   localparam int DW = $clog2(MAX_LEN + 1);
   localparam int VW = $clog2(MAX_LEN + 2);

   logic [LEN_W-1:0] seq_length_ff;
   logic             rsp_valid_ff;
   rsp_type          rsp_ff;

   logic             out_free, rsp_load;
   rsp_type          rsp_next;
   logic             mem_we;
   logic [AW-1:0]    mem_wr_addr, mem_rd_addr;
   logic [VW-1:0]    mem_wr_data, mem_rd_data;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_length_ff <= LEN_RESET;
      end else if (csr_valid) begin
         seq_length_ff <= csr_data;
      end
   end

   assign out_free = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_ff <= rsp_next;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, rsp_ff.failed, rsp_ff.push_count};
   assign rsp_tlast  = rsp_ff.last;

   scc_seq_ctrl #(
      .MAX_LEN (MAX_LEN),
      .AW      (AW),
      .DW      (DW),
      .VW      (VW)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .seq_length  (seq_length_ff),
      .req_valid   (req_tvalid),
      .req_target  (req_tdata[TARGET_W-1:0]),
      .req_ready   (req_tready),
      .out_free    (out_free),
      .rsp_load    (rsp_load),
      .rsp_data    (rsp_next),
      .mem_we      (mem_we),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data)
   );

   scc_stack_mem #(
      .AW (AW),
      .VW (VW)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

endmodule

`default_nettype wire

FILE: rtl/scc_stack_mem.sv
// ----------------------------------------------------------------------------
// scc_stack_mem
// Stack storage: one write port, one registered read port with
// write-to-read forwarding so the top entry is always current.
// ----------------------------------------------------------------------------
`default_nettype none

module scc_stack_mem #(
   parameter int AW = 8,
   parameter int VW = 9
) (
   input  wire logic          clock,
   input  wire logic          wr_en,
   input  wire logic [AW-1:0] wr_addr,
   input  wire logic [VW-1:0] wr_data,
   input  wire logic [AW-1:0] rd_addr,
   output logic      [VW-1:0] rd_data
);

   logic [VW-1:0] mem [2**AW];
   logic [VW-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en && (wr_addr == rd_addr)) begin
         rd_data_ff <= wr_data;
      end else begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: rtl/scc_seq_ctrl.sv
// ----------------------------------------------------------------------------
// scc_seq_ctrl
// Sequencer: compares each target with the stack top, pops, or pushes the
// missing values one per cycle, and tracks depth, next value and fail flag.
// ----------------------------------------------------------------------------
`default_nettype none

module scc_seq_ctrl #(
   parameter int MAX_LEN = scc_pkg::DEF_MAX_LEN,
   parameter int AW      = 8,
   parameter int DW      = 9,
   parameter int VW      = 9
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic [scc_pkg::LEN_W-1:0]    seq_length,
   input  wire logic                         req_valid,
   input  wire logic [scc_pkg::TARGET_W-1:0] req_target,
   output logic                              req_ready,
   input  wire logic                         out_free,
   output logic                              rsp_load,
   output scc_pkg::rsp_type                  rsp_data,
   output logic                              mem_we,
   output logic      [AW-1:0]                mem_wr_addr,
   output logic      [VW-1:0]                mem_wr_data,
   output logic      [AW-1:0]                mem_rd_addr,
   input  wire logic [VW-1:0]                mem_rd_data
);

   import scc_pkg::*;

   localparam int CW = (VW > TARGET_W) ? VW : TARGET_W;
   localparam logic [CW-1:0] MAX_C = CW'(MAX_LEN);

   state_type            state_ff, state_in;
   logic [DW-1:0]        depth_ff, depth_in;
   logic [VW-1:0]        next_ff, next_in;
   logic [DW-1:0]        items_ff, items_in;
   logic                 fail_ff, fail_in;
   logic [TARGET_W-1:0]  target_ff, target_in;
   logic [COUNT_W-1:0]   pcnt_ff, pcnt_in;

   logic [CW-1:0]        len_c, n_c, tgt_c, next_c, top_c, items_c;
   logic [DW-1:0]        items_inc, depth_dec;
   logic                 finish, is_last;
   logic [COUNT_W-1:0]   fin_pushes;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         depth_ff <= '0;
         next_ff  <= VW'(1);
         items_ff <= '0;
         fail_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         depth_ff <= depth_in;
         next_ff  <= next_in;
         items_ff <= items_in;
         fail_ff  <= fail_in;
      end
   end

   always_ff @(posedge clock) begin
      target_ff <= target_in;
      pcnt_ff   <= pcnt_in;
   end

   always_comb begin
      len_c = CW'(seq_length);
      if (len_c == '0) begin
         n_c = CW'(1);
      end else if (len_c > MAX_C) begin
         n_c = MAX_C;
      end else begin
         n_c = len_c;
      end
   end

   assign tgt_c     = CW'(target_ff);
   assign next_c    = CW'(next_ff);
   assign top_c     = CW'(mem_rd_data);
   assign items_inc = items_ff + DW'(1);
   assign items_c   = CW'(items_inc);
   assign is_last   = (items_c >= n_c);

   always_comb begin
      state_in    = state_ff;
      depth_in    = depth_ff;
      next_in     = next_ff;
      items_in    = items_ff;
      fail_in     = fail_ff;
      target_in   = target_ff;
      pcnt_in     = pcnt_ff;
      req_ready   = 1'b0;
      mem_we      = 1'b0;
      mem_wr_addr = depth_ff[AW-1:0];
      mem_wr_data = next_ff;
      finish      = 1'b0;
      fin_pushes  = '0;
      rsp_load    = 1'b0;
      rsp_data    = '0;

      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               target_in = req_target;
               state_in  = ST_EVAL;
            end
         end
         ST_EVAL: begin
            if (out_free) begin
               if (fail_ff) begin
                  finish = 1'b1;
               end else if ((depth_ff != '0) && (top_c == tgt_c)) begin
                  depth_in = depth_ff - DW'(1);
                  finish   = 1'b1;
               end else if ((tgt_c >= next_c) && (tgt_c <= n_c)) begin
                  pcnt_in  = COUNT_W'(tgt_c - next_c + CW'(1));
                  state_in = ST_PUSH;
               end else begin
                  fail_in = 1'b1;
                  finish  = 1'b1;
               end
            end
         end
         ST_PUSH: begin
            if (next_c < tgt_c) begin
               mem_we   = 1'b1;
               depth_in = depth_ff + DW'(1);
               next_in  = next_ff + VW'(1);
            end else if (out_free) begin
               next_in    = VW'(tgt_c + CW'(1));
               fin_pushes = pcnt_ff;
               finish     = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (finish) begin
         rsp_load            = 1'b1;
         rsp_data.push_count = fail_in ? '0 : fin_pushes;
         rsp_data.failed     = fail_in;
         rsp_data.last       = is_last;
         state_in            = ST_IDLE;
         if (is_last) begin
            depth_in = '0;
            next_in  = VW'(1);
            items_in = '0;
            fail_in  = 1'b0;
         end else begin
            items_in = items_inc;
         end
      end
   end

   // top of stack for the next depth; data is stale only when depth is zero
   assign depth_dec   = depth_in - DW'(1);
   assign mem_rd_addr = depth_dec[AW-1:0];

endmodule

`default_nettype wire

FILE: dv/stack_sequence_checker_unit_test.sv
// ----------------------------------------------------------------------------
// stack_sequence_checker_unit_test
// Self-checking testbench for the stack sequence checker.
// ----------------------------------------------------------------------------
// A queue of pop targets and length writes feeds a clocked driver. Each
// accepted target runs through a behavioral stack model, and the expected
// push count, fail flag and last marker are queued. A clocked monitor compares
// each result transaction against the oldest expectation. Directed cases hit
// the corner cases; random sequences follow, mostly legal pop orders with
// some corrupted or pure noise sequences, and length writes between phases.
// Both sides idle at random.
// ----------------------------------------------------------------------------

module stack_sequence_checker_unit_test;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_LEN        = scc_pkg::DEF_MAX_LEN;
   localparam int RANDOM_TARGETS = 700;
   localparam int IDLE_LIMIT     = 4000;
   localparam int TAIL_CYCLES    = 16;

   typedef enum logic [1:0] {
      STIM_TARGET,
      STIM_LENGTH,
      STIM_SETTLE
   } stim_kind_type;

   typedef enum logic [1:0] {
      SEQ_CLEAN,
      SEQ_BROKEN,
      SEQ_NOISE
   } seq_shape_type;

   typedef struct packed {
      stim_kind_type kind;
      logic [8:0]    value;
   } stim_type;

   logic                        clock      = 1'b0;
   logic                        reset      = 1'b1;
   logic                        csr_valid  = 1'b0;
   logic                        csr_ready;
   logic [scc_pkg::LEN_W-1:0]   csr_data   = '0;
   logic                        req_tvalid = 1'b0;
   logic                        req_tready;
   logic [15:0]                 req_tdata  = '0;  // [8:0] target
   logic                        rsp_tvalid;
   logic                        rsp_tready = 1'b0;
   logic [15:0]                 rsp_tdata;        // [8:0] push_count, [9] failed
   logic                        rsp_tlast;

   stim_type                    stim_q[$];
   scc_pkg::rsp_type            outcome_q[$];

   // stack model
   logic [8:0]                  stk [MAX_LEN];
   int                          stk_depth   = 0;
   int                          next_val    = 1;
   int                          items_seen  = 0;
   bit                          chk_failed  = 1'b0;
   logic [8:0]                  seq_len     = scc_pkg::LEN_RESET;

   // stimulus generation bookkeeping
   int                          gen_n       = MAX_LEN;
   int                          gen_seen    = 0;
   int                          gen_targets = 0;

   // handshake flags between monitor and driver
   bit                          req_taken   = 1'b0;
   bit                          csr_taken   = 1'b0;
   bit                          rsp_taken   = 1'b0;
   bit                          req_burst   = 1'b0;
   bit                          rsp_burst   = 1'b0;
   int                          req_gap     = 0;
   int                          rsp_stall   = 0;

   int                          errors        = 0;
   int                          idle_cycles   = 0;
   int                          targets_sent  = 0;
   int                          length_writes = 0;
   int                          seq_done      = 0;
   int                          seq_failed    = 0;

   stack_sequence_checker_unit #(
      .MAX_LEN(MAX_LEN)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always #4 clock = ~clock;

   function automatic int eff_len(input logic [8:0] raw);
      if (raw == 0) return 1;
      if (raw > MAX_LEN) return MAX_LEN;
      return raw;
   endfunction

   function automatic scc_pkg::rsp_type pop_outcome(input logic [8:0] target);
      scc_pkg::rsp_type r;
      int n;
      int pushes;
      int t;
      n      = eff_len(seq_len);
      pushes = 0;
      t      = target;
      if (!chk_failed) begin
         if (stk_depth > 0 && stk[stk_depth-1] == target) begin
            stk_depth--;
         end else if (t >= next_val && t <= n) begin
            pushes = t - next_val + 1;
            while (next_val < t) begin
               stk[stk_depth] = next_val[8:0];
               stk_depth++;
               next_val++;
            end
            next_val = t + 1;
         end else begin
            chk_failed = 1'b1;
         end
      end
      items_seen++;
      r.last       = (items_seen >= n);
      r.failed     = chk_failed;
      r.push_count = chk_failed ? '0 : pushes[8:0];
      if (r.last) begin
         stk_depth  = 0;
         next_val   = 1;
         items_seen = 0;
         chk_failed = 1'b0;
      end
      return r;
   endfunction

   task automatic queue_stim(input stim_kind_type kind, input int value);
      stim_type s;
      s.kind  = kind;
      s.value = value[8:0];
      stim_q.push_back(s);
   endtask

   task automatic add_target(input int value);
      queue_stim(STIM_TARGET, value);
      gen_targets++;
      gen_seen++;
      if (gen_seen >= gen_n) gen_seen = 0;
   endtask

   task automatic set_length(input int raw);
      queue_stim(STIM_LENGTH, raw);
      gen_n = eff_len(raw[8:0]);
   endtask

   function automatic int noise_target(input int n);
      if ($urandom_range(0, 3) == 0) return $urandom_range(0, 511);
      return $urandom_range(0, n + 1);
   endfunction

   // legal pop order of 1..n, optionally damaged, first len entries queued
   task automatic add_sequence(input int n, input seq_shape_type shape, input int len);
      int held[$];
      int order[$];
      int nxt;
      int pick;
      int idx;
      int tmp;
      nxt = 1;
      while (order.size() < n) begin
         if (held.size() > 0 && (nxt > n || $urandom_range(0, 2) == 0)) begin
            order.push_back(held.pop_back());
         end else begin
            if ($urandom_range(0, 3) == 0) pick = $urandom_range(nxt, n);
            else pick = $urandom_range(nxt, (nxt + 2 > n) ? n : nxt + 2);
            while (nxt < pick) begin
               held.push_back(nxt);
               nxt++;
            end
            order.push_back(pick);
            nxt = pick + 1;
         end
      end
      if (shape == SEQ_BROKEN) begin
         idx = $urandom_range(0, n - 1);
         if (n > 1 && idx < n - 1 && $urandom_range(0, 1) == 0) begin
            tmp          = order[idx];
            order[idx]   = order[idx+1];
            order[idx+1] = tmp;
         end else begin
            order[idx] = noise_target(n);
         end
      end else if (shape == SEQ_NOISE) begin
         foreach (order[k]) order[k] = noise_target(n);
      end
      for (int k = 0; k < len; k++) add_target(order[k]);
   endtask

   task automatic build_directed();
      set_length(4);
      add_target(4); add_target(3); add_target(2); add_target(1);
      queue_stim(STIM_SETTLE, 0);
      add_target(1); add_target(2); add_target(3); add_target(4);
      // pop below top fails, then sticky
      add_target(3); add_target(1); add_target(2); add_target(4);
      set_length(3);
      add_target(0); add_target(1); add_target(2);
      add_target(2); add_target(511); add_target(3);
      // second 1 meets an empty stack
      add_target(1); add_target(1); add_target(2);
      set_length(0);
      add_target(1); add_target(256);
      set_length(511);
      add_target(256);
      // shorter length written mid-sequence
      set_length(1);
      add_target(255);
   endtask

   task automatic build_random();
      int start;
      int pick;
      int raw;
      int count;
      int big_left;
      int shape;
      start    = gen_targets;
      big_left = 1;
      while (gen_targets - start < RANDOM_TARGETS) begin
         pick = $urandom_range(0, 19);
         if (pick == 0 && big_left > 0) begin
            raw = $urandom_range(0, 1) ? 256 : $urandom_range(257, 511);
            big_left--;
         end else if (pick == 1) begin
            raw = $urandom_range(0, 1);
         end else if (pick < 5) begin
            raw = $urandom_range(13, 40);
         end else begin
            raw = $urandom_range(2, 12);
         end
         set_length(raw);
         while (gen_seen != 0) add_target(noise_target(gen_n));
         count = (gen_n == MAX_LEN) ? 1 : $urandom_range(1, 5);
         repeat (count) begin
            shape = $urandom_range(0, 9);
            if (shape < 7) add_sequence(gen_n, SEQ_CLEAN, gen_n);
            else if (shape < 9) add_sequence(gen_n, SEQ_BROKEN, gen_n);
            else add_sequence(gen_n, SEQ_NOISE, gen_n);
         end
         if (gen_n > 1 && $urandom_range(0, 4) == 0)
            add_sequence(gen_n, SEQ_CLEAN, $urandom_range(1, gen_n - 1));
         if ($urandom_range(0, 7) == 0) queue_stim(STIM_SETTLE, 0);
      end
   endtask

   // driver
   always @(negedge clock) begin
      logic     req_v;
      logic     csr_v;
      stim_type head;
      if (reset) begin
         req_tvalid <= 1'b0;
         csr_valid  <= 1'b0;
         rsp_tready <= 1'b0;
      end else begin
         req_v = req_tvalid;
         csr_v = csr_valid;
         if (req_taken) begin
            req_v     = 1'b0;
            req_taken = 1'b0;
         end
         if (csr_taken) begin
            csr_v     = 1'b0;
            csr_taken = 1'b0;
         end
         if (!req_v && !csr_v && stim_q.size() > 0) begin
            if (req_gap > 0) begin
               req_gap--;
            end else begin
               head = stim_q[0];
               case (head.kind)
                  STIM_TARGET: begin
                     req_v = 1'b1;
                     req_tdata <= {7'd0, head.value};
                     void'(stim_q.pop_front());
                     if ($urandom_range(0, 31) == 0) req_burst = !req_burst;
                     req_gap = req_burst ? 0 : $urandom_range(0, 7);
                  end
                  STIM_LENGTH: if (outcome_q.size() == 0) begin
                     csr_v = 1'b1;
                     csr_data <= head.value;
                     void'(stim_q.pop_front());
                  end
                  default: if (outcome_q.size() == 0) begin
                     void'(stim_q.pop_front());
                  end
               endcase
            end
         end
         req_tvalid <= req_v;
         csr_valid  <= csr_v;

         if (rsp_taken) begin
            rsp_taken = 1'b0;
            if ($urandom_range(0, 31) == 0) rsp_burst = !rsp_burst;
            rsp_stall = rsp_burst ? 0 : $urandom_range(0, 7);
         end
         if (rsp_stall > 0) begin
            rsp_tready <= 1'b0;
            rsp_stall--;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // monitor, scoreboard and watchdog
   always @(posedge clock) begin
      scc_pkg::rsp_type want;
      scc_pkg::rsp_type got;
      bit               moved;
      if (!reset) begin
         moved = 1'b0;
         if (csr_valid && csr_ready) begin
            seq_len   = csr_data;
            csr_taken = 1'b1;
            moved     = 1'b1;
            length_writes++;
         end
         if (req_tvalid && req_tready) begin
            outcome_q.push_back(pop_outcome(req_tdata[8:0]));
            req_taken = 1'b1;
            moved     = 1'b1;
            targets_sent++;
         end
         if (rsp_tvalid && rsp_tready) begin
            rsp_taken       = 1'b1;
            moved           = 1'b1;
            got.push_count  = rsp_tdata[8:0];
            got.failed      = rsp_tdata[9];
            got.last        = rsp_tlast;
            if (outcome_q.size() == 0) begin
               errors++;
               $display("%0t: unexpected result, expected none, actual %0d/%0b/%0b",
                        $time, got.push_count, got.failed, got.last);
            end else begin
               want = outcome_q.pop_front();
               if (got.push_count !== want.push_count) begin
                  errors++;
                  $display("%0t: push_count expected %0d actual %0d",
                           $time, want.push_count, got.push_count);
               end
               if (got.failed !== want.failed) begin
                  errors++;
                  $display("%0t: failed expected %0b actual %0b",
                           $time, want.failed, got.failed);
               end
               if (got.last !== want.last) begin
                  errors++;
                  $display("%0t: last expected %0b actual %0b",
                           $time, want.last, got.last);
               end
               if (want.last) begin
                  seq_done++;
                  if (want.failed) seq_failed++;
               end
            end
         end
         if (moved) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
            $display("stack_sequence_checker_unit: mismatch");
            $finish;
         end
      end
   end

   initial begin
      build_directed();
      build_random();
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      while (stim_q.size() > 0 || req_tvalid || csr_valid || outcome_q.size() > 0)
         @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      $display("checked %0d targets under %0d length writes", targets_sent, length_writes);
      $display("%0d sequences completed, %0d of them judged impossible", seq_done, seq_failed);
      if (errors == 0) begin
         $display("stack_sequence_checker_unit: match");
      end else begin
         $display("stack_sequence_checker_unit: mismatch");
      end
      $finish;
   end

endmodule

FILE: files.f
rtl/scc_pkg.sv
rtl/scc_stack_mem.sv
rtl/scc_seq_ctrl.sv
rtl/stack_sequence_checker_unit.sv
dv/stack_sequence_checker_unit_test.sv
